// File: design/lpd_pkg.sv
// ---------------------------------------------------------------------------
// lpd_pkg: shared definitions for the length-prefixed deframer
// Constants, result codes and the result record used by the core, the
// output queue and the output channel.
// ---------------------------------------------------------------------------
package lpd_pkg;

  // Receive buffer size the length header is checked against.
  localparam int BUFFER_BYTES = 4096;
  // Header is one 32-bit little-endian signed word.
  localparam int HEADER_BYTES = 4;
  // A good length is strictly below this.
  localparam int MAX_LEN      = BUFFER_BYTES - HEADER_BYTES;
  // Width of the remaining-body counter: holds any good length.
  localparam int REM_W        = $clog2(MAX_LEN);

  typedef enum logic [1:0] {
    KIND_BODY       = 2'd0,
    KIND_BAD_LENGTH = 2'd1,
    KIND_LINK_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_byte;
    logic       last_of_packet;
  } result_t;

endpackage

// File: design/lpd_in_if.sv
// ---------------------------------------------------------------------------
// lpd_in_if: received byte channel
// Valid/ready channel carrying one stream byte or a link error flag.
// ---------------------------------------------------------------------------
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       link_error;

  modport source (output valid, output data_byte, output link_error, input ready);
  modport sink   (input valid, input data_byte, input link_error, output ready);
endinterface

// File: design/lpd_out_if.sv
// ---------------------------------------------------------------------------
// lpd_out_if: deframed result channel
// Valid/ready channel carrying body bytes and close events.
// ---------------------------------------------------------------------------
interface lpd_out_if;
  logic            valid;
  logic            ready;
  lpd_pkg::kind_t  kind;
  logic [7:0]      body_byte;
  logic            last_of_packet;

  modport source (output valid, output kind, output body_byte, output last_of_packet,
                  input ready);
  modport sink   (input valid, input kind, input body_byte, input last_of_packet,
                  output ready);
endinterface

// File: design/lpd_core.sv
// ---------------------------------------------------------------------------
// lpd_core: input register, framing state and per-byte decision
// Registers the incoming transaction, then updates header/body state and
// emits at most one result per byte into the output queue.
// ---------------------------------------------------------------------------
module lpd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             link_error,
  input  logic             space,
  output logic             push,
  output lpd_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_CLOSED = 2'd2
  } phase_t;

  phase_t                    phase, phase_next;
  logic [1:0]                header_count, header_count_next;
  logic [23:0]               length_accum, length_accum_next;
  logic [lpd_pkg::REM_W-1:0] body_remaining, body_remaining_next;

  logic       in_v;
  logic [7:0] in_data;
  logic       in_err;

  logic        has_res;
  logic        advance;
  logic        bad_len;
  logic        last;
  logic [31:0] length;

  assign length  = {in_data, length_accum};
  assign bad_len = (length == 32'd0) || length[31] ||
                   (length >= 32'(lpd_pkg::MAX_LEN));
  assign last    = (body_remaining <= lpd_pkg::REM_W'(1));

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    length_accum_next   = length_accum;
    body_remaining_next = body_remaining;
    has_res             = 1'b0;
    res                 = '{kind: lpd_pkg::KIND_BODY, body_byte: 8'h00, last_of_packet: 1'b0};
    case (phase)
      PH_HEADER: begin
        if (in_err) begin
          phase_next = PH_CLOSED;
          has_res    = 1'b1;
          res.kind   = lpd_pkg::KIND_LINK_ERROR;
        end else if (header_count == 2'd3) begin
          header_count_next = 2'd0;
          if (bad_len) begin
            phase_next = PH_CLOSED;
            has_res    = 1'b1;
            res.kind   = lpd_pkg::KIND_BAD_LENGTH;
          end else begin
            body_remaining_next = length[lpd_pkg::REM_W-1:0];
            length_accum_next   = 24'd0;
            phase_next          = PH_BODY;
          end
        end else begin
          header_count_next = header_count + 2'd1;
          case (header_count)
            2'd0:    length_accum_next[7:0]   = in_data;
            2'd1:    length_accum_next[15:8]  = in_data;
            default: length_accum_next[23:16] = in_data;
          endcase
        end
      end
      PH_BODY: begin
        if (in_err) begin
          phase_next = PH_CLOSED;
          has_res    = 1'b1;
          res.kind   = lpd_pkg::KIND_LINK_ERROR;
        end else begin
          has_res            = 1'b1;
          res.body_byte      = in_data;
          res.last_of_packet = last;
          if (last) begin
            body_remaining_next = '0;
            length_accum_next   = 24'd0;
            header_count_next   = 2'd0;
            phase_next          = PH_HEADER;
          end else begin
            body_remaining_next = body_remaining - lpd_pkg::REM_W'(1);
          end
        end
      end
      default: begin
        // closed (or unused code): swallow everything
      end
    endcase
  end

  assign advance  = in_v && (!has_res || space);
  // not ready while in reset, so nothing is taken and dropped
  assign in_ready = !rst && (!in_v || advance);
  assign push     = advance && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v           <= 1'b0;
      phase          <= PH_HEADER;
      header_count   <= 2'd0;
      length_accum   <= 24'd0;
      body_remaining <= '0;
    end else begin
      if (in_ready) begin
        in_v <= in_valid;
      end
      if (advance) begin
        phase          <= phase_next;
        header_count   <= header_count_next;
        length_accum   <= length_accum_next;
        body_remaining <= body_remaining_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_data <= data_byte;
      in_err  <= link_error;
    end
  end

endmodule

// File: design/lpd_out_fifo.sv
// ---------------------------------------------------------------------------
// lpd_out_fifo: two-entry result queue
// Holds results so the sink can stall without the stall reaching the
// input side combinationally.
// ---------------------------------------------------------------------------
module lpd_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpd_pkg::result_t din,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output lpd_pkg::result_t dout
);

  lpd_pkg::result_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign dout      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

endmodule

// File: design/length_prefixed_deframer.sv
// ---------------------------------------------------------------------------
// length_prefixed_deframer: byte stream to packet body deframer
// Gathers a 4-byte little-endian signed length header, passes that many
// body bytes through with the last one marked, and closes on a bad length
// or a link error.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+------------
//  rx      | in  | data_byte[7:0], link_error               | valid/ready
//  pkt     | out | kind[1:0], body_byte[7:0], last_of_packet| valid/ready
//
//  One transaction per cycle sustained while pkt does not stall; a result passes
//  through the input register and then the queue before it shows on pkt.
//  Header bytes and a good length give no result; every body byte gives one.
//  rst is synchronous: header phase, queue empty, rx held not ready.
//  A stall on pkt fills the two-entry queue; rx.ready drops once it is full
//  and the registered byte has a result to place. After a close rx is drained.
// ---------------------------------------------------------------------------
module length_prefixed_deframer (
  input  logic      clk,
  input  logic      rst,
  lpd_in_if.sink    rx,
  lpd_out_if.source pkt
);

  logic             space;
  logic             push;
  lpd_pkg::result_t res;
  lpd_pkg::result_t head;

  // Input register plus framing state; decides one result per byte.
  lpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .data_byte  (rx.data_byte),
    .link_error (rx.link_error),
    .space      (space),
    .push       (push),
    .res        (res)
  );

  // Result queue; its registered "space" decouples pkt.ready from rx.ready.
  lpd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .space     (space),
    .out_valid (pkt.valid),
    .out_ready (pkt.ready),
    .dout      (head)
  );

  assign pkt.kind           = head.kind;
  assign pkt.body_byte      = head.body_byte;
  assign pkt.last_of_packet = head.last_of_packet;

endmodule

// File: design/lpd_checker.sv
// ---------------------------------------------------------------------------
// lpd_checker: port-level checks for the deframer
// Watches the result channel over time; bound to the top level.
// ---------------------------------------------------------------------------
module lpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       pkt_valid,
  input logic       pkt_ready,
  input logic [1:0] pkt_kind,
  input logic [7:0] pkt_body_byte,
  input logic       pkt_last
);

  logic closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed <= 1'b0;
    end else if (pkt_valid && pkt_ready && (pkt_kind != lpd_pkg::KIND_BODY)) begin
      closed <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt_kind) &&
      $stable(pkt_body_byte) && $stable(pkt_last))
    else $error("result changed while stalled");

  a_close_fields: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && (pkt_kind != lpd_pkg::KIND_BODY) |-> (pkt_body_byte == 8'h00) && !pkt_last)
    else $error("close result carries body fields");

  a_silent_after_close: assert property (@(posedge clk) disable iff (rst)
    closed |-> !pkt_valid)
    else $error("result after close");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pkt_valid)
    else $error("result valid right after reset");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
  .clk           (clk),
  .rst           (rst),
  .pkt_valid     (pkt.valid),
  .pkt_ready     (pkt.ready),
  .pkt_kind      (pkt.kind),
  .pkt_body_byte (pkt.body_byte),
  .pkt_last      (pkt.last_of_packet)
);
